// ===== hw/rtl/upt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upt_pkg: shared types and functions of the UTF-8 pre-tokenizer
// Holds the queue entry format, the result kinds and the decode and
// classification functions used by the front end.
// ----------------------------------------------------------------------------
package upt_pkg;

    // result kinds, plus an internal code for whitespace
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_STAND = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_SPACE = 2'd3;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // up to four held bytes, byte 0 in the lowest bits
    typedef logic [3:0][7:0] upt_buf_t;

    // one character request between front end and back end
    typedef struct packed {
        logic [1:0]  op;
        logic [20:0] cp;
        logic        last;
    } upt_entry_t;

    // push request into the queue
    typedef struct packed {
        logic       valid;
        upt_entry_t entry;
    } upt_push_t;

    // result of classifying one code point
    typedef struct packed {
        logic        keep;
        logic [1:0]  op;
        logic [20:0] cp;
    } upt_class_t;

    // sequence length from a lead byte, zero for an invalid lead
    function automatic logic [2:0] lead_length(logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    // assemble a code point from lead and continuation bytes
    function automatic logic [20:0] decode_seq(upt_buf_t s, logic [2:0] len);
        logic [20:0] cp;
        case (len)
            3'd2:    cp = {10'd0, s[0][4:0], s[1][5:0]};
            3'd3:    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            3'd4:    cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
            default: cp = {13'd0, s[0]};
        endcase
        return cp;
    endfunction

    function automatic logic is_cjk(logic [20:0] c);
        return (c >= 21'h03400 && c <= 21'h04DBF) ||
               (c >= 21'h04E00 && c <= 21'h09FFF) ||
               (c >= 21'h0F900 && c <= 21'h0FAFF) ||
               (c >= 21'h20000 && c <= 21'h2A6DF) ||
               (c >= 21'h2A700 && c <= 21'h2CEAF) ||
               (c >= 21'h2F800 && c <= 21'h2FA1F);
    endfunction

    function automatic logic is_punct(logic [20:0] c);
        return (c >= 21'h00021 && c <= 21'h0002F) ||
               (c >= 21'h0003A && c <= 21'h00040) ||
               (c >= 21'h0005B && c <= 21'h00060) ||
               (c >= 21'h0007B && c <= 21'h0007E) ||
               (c >= 21'h02000 && c <= 21'h0206F) ||
               (c >= 21'h02E00 && c <= 21'h02E7F) ||
               (c >= 21'h03001 && c <= 21'h0303F) ||
               (c >= 21'h0FE10 && c <= 21'h0FE1F) ||
               (c >= 21'h0FE30 && c <= 21'h0FE4F) ||
               (c >= 21'h0FF01 && c <= 21'h0FF65);
    endfunction

    function automatic logic is_space(logic [20:0] c);
        return c == 21'h00020 || c == 21'h00009 || c == 21'h0000A ||
               c == 21'h0000D || c == 21'h000A0 || c == 21'h01680 ||
               (c >= 21'h02000 && c <= 21'h0200A) ||
               c == 21'h02028 || c == 21'h02029 || c == 21'h0202F ||
               c == 21'h0205F || c == 21'h03000;
    endfunction

    function automatic logic is_ctrl(logic [20:0] c);
        logic tab_nl;
        tab_nl = c == 21'h00009 || c == 21'h0000A || c == 21'h0000D;
        return !tab_nl && (c < 21'h00020 || (c >= 21'h0007F && c <= 21'h0009F) ||
                           c == REPLACEMENT_CP);
    endfunction

    // control chars and replacement are dropped, capitals lowered
    function automatic upt_class_t classify(logic [20:0] c);
        upt_class_t r;
        logic [20:0] lc;
        lc = (c >= 21'h00041 && c <= 21'h0005A) ? c + 21'h00020 : c;
        r.keep = !is_ctrl(c);
        r.cp   = lc;
        if (is_space(c))
            r.op = KIND_SPACE;
        else if (is_cjk(lc) || is_punct(lc))
            r.op = KIND_STAND;
        else
            r.op = KIND_WORD;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf8_pretokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_pretokenizer: streaming UTF-8 basic pre-tokenizer
// Decodes UTF-8 text bytes into lowercased characters tagged as word or
// standalone token characters, followed by an end-of-text result.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle and keeps that rate as long as results are
// taken; each byte causes at most one result, except the byte marked last.
// After that byte the decoder stops taking input while it re-parses the cnt
// (1 to 4) bytes then held, that byte included: it takes a single byte or a
// whole sequence from the head at a time, then pushes the end marker, and
// waits while the queue is full. A byte's result is registered on its way
// out, first into the queue, then into the output register. The queue of
// FIFO_DEPTH characters lets decoding run ahead of a stalled output. Results
// carry the code point and token-start flag in tdata, the kind in tuser and
// the last result of each input byte in tlast.
module utf8_pretokenizer #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [21] starts_token
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // run_end
);
    import upt_pkg::*;

    upt_push_t   push;
    upt_entry_t  head;
    logic        full;
    logic        empty;
    logic        pop;
    logic [20:0] cp;
    logic        start;

    // byte intake and decode
    upt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_final (s_axis_tlast),
        .full     (full),
        .push     (push)
    );

    // character queue
    upt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .head  (head)
    );

    // word tracking and output register
    upt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_cp    (cp),
        .out_start (start),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, start, cp};

endmodule
`default_nettype wire

// ===== hw/rtl/upt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upt_front: byte intake and UTF-8 decode
// Gathers multi-byte sequences, decodes and classifies characters and
// pushes them into the queue; re-parses held bytes after the final byte.
// ----------------------------------------------------------------------------
module upt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_final,
    input  wire logic             full,
    output upt_pkg::upt_push_t    push
);
    import upt_pkg::*;

    upt_buf_t   pb_reg, pb_next;
    logic [2:0] pcnt_reg, pcnt_next;
    logic [2:0] plen_reg, plen_next;
    logic       flush_reg, flush_next;

    upt_buf_t   in_buf;
    logic [2:0] cnt_inc;
    logic [2:0] lead_len;
    logic [2:0] head_len;
    logic [2:0] amt;
    upt_class_t cls;

    assign in_ready = !flush_reg && !full;

    // sequence gathering and end-of-text re-parse
    always_comb
    begin
        pb_next    = pb_reg;
        pcnt_next  = pcnt_reg;
        plen_next  = plen_reg;
        flush_next = flush_reg;
        push       = '0;
        in_buf     = pb_reg;
        in_buf[pcnt_reg[1:0]] = in_byte;
        cnt_inc    = pcnt_reg + 3'd1;
        lead_len   = lead_length(in_byte);
        head_len   = lead_length(pb_reg[0]);
        amt        = 3'd1;
        cls        = '0;

        if (flush_reg)
        begin
            if (!full)
            begin
                if (pcnt_reg == 3'd0)
                begin
                    // all held bytes done: end marker
                    push.valid      = 1'b1;
                    push.entry.op   = KIND_END;
                    push.entry.cp   = '0;
                    push.entry.last = 1'b1;
                    flush_next      = 1'b0;
                    pb_next         = '0;
                    plen_next       = 3'd0;
                end
                else
                begin
                    // one character or invalid byte from the head of the buffer per cycle while the queue has room
                    if (head_len == 3'd1)
                    begin
                        cls = classify({13'd0, pb_reg[0]});
                    end
                    else if (head_len != 3'd0 && head_len <= pcnt_reg)
                    begin
                        cls = classify(decode_seq(pb_reg, head_len));
                        amt = head_len;
                    end
                    push.valid      = cls.keep;
                    push.entry.op   = cls.op;
                    push.entry.cp   = cls.cp;
                    push.entry.last = 1'b0;
                    case (amt)
                        3'd1:    pb_next = pb_reg >> 8;
                        3'd2:    pb_next = pb_reg >> 16;
                        3'd3:    pb_next = pb_reg >> 24;
                        default: pb_next = '0;
                    endcase
                    pcnt_next = pcnt_reg - amt;
                end
            end
        end
        else if (in_valid && in_ready)
        begin
            if (in_final)
            begin
                pb_next    = in_buf;
                pcnt_next  = cnt_inc;
                flush_next = 1'b1;
            end
            else if (pcnt_reg == 3'd0)
            begin
                if (lead_len == 3'd1)
                begin
                    cls             = classify({13'd0, in_byte});
                    push.valid      = cls.keep;
                    push.entry.op   = cls.op;
                    push.entry.cp   = cls.cp;
                    push.entry.last = 1'b1;
                end
                else if (lead_len != 3'd0)
                begin
                    pb_next    = '0;
                    pb_next[0] = in_byte;
                    pcnt_next  = 3'd1;
                    plen_next  = lead_len;
                end
            end
            else if (cnt_inc >= plen_reg || cnt_inc >= 3'd4)
            begin
                // sequence complete
                cls             = classify(decode_seq(in_buf, plen_reg));
                push.valid      = cls.keep;
                push.entry.op   = cls.op;
                push.entry.cp   = cls.cp;
                push.entry.last = 1'b1;
                pb_next         = '0;
                pcnt_next       = 3'd0;
                plen_next       = 3'd0;
            end
            else
            begin
                pb_next   = in_buf;
                pcnt_next = cnt_inc;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg    <= '0;
            pcnt_reg  <= 3'd0;
            plen_reg  <= 3'd0;
            flush_reg <= 1'b0;
        end
        else
        begin
            pb_reg    <= pb_next;
            pcnt_reg  <= pcnt_next;
            plen_reg  <= plen_next;
            flush_reg <= flush_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/upt_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upt_fifo: character queue between front end and back end
// Small register-based queue so that decode and output stall independently.
// ----------------------------------------------------------------------------
module upt_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire upt_pkg::upt_push_t push,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output upt_pkg::upt_entry_t     head
);
    import upt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upt_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("push request into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop request from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/upt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upt_back: word tracking and result output
// Takes characters from the queue, tracks the open word, marks token
// starts and holds each result in an output register.
// ----------------------------------------------------------------------------
module upt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire upt_pkg::upt_entry_t head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               out_kind,
    output logic [20:0]              out_cp,
    output logic                     out_start,
    output logic                     out_last
);
    import upt_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [20:0] cp_reg, cp_next;
    logic        start_reg, start_next;
    logic        last_reg, last_next;
    logic        word_open_reg, word_open_next;

    // whitespace needs no output slot
    assign pop = !empty && (head.op == KIND_SPACE || !valid_reg || out_ready);

    always_comb
    begin
        valid_next     = valid_reg && !out_ready;
        kind_next      = kind_reg;
        cp_next        = cp_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        word_open_next = word_open_reg;
        if (pop)
        begin
            case (head.op)
                KIND_WORD:
                begin
                    valid_next     = 1'b1;
                    kind_next      = KIND_WORD;
                    cp_next        = head.cp;
                    start_next     = !word_open_reg;
                    last_next      = head.last;
                    word_open_next = 1'b1;
                end
                KIND_STAND:
                begin
                    valid_next     = 1'b1;
                    kind_next      = KIND_STAND;
                    cp_next        = head.cp;
                    start_next     = 1'b1;
                    last_next      = head.last;
                    word_open_next = 1'b0;
                end
                KIND_END:
                begin
                    valid_next     = 1'b1;
                    kind_next      = KIND_END;
                    cp_next        = '0;
                    start_next     = 1'b0;
                    last_next      = 1'b1;
                    word_open_next = 1'b0;
                end
                default:
                begin
                    word_open_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            word_open_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            word_open_reg <= word_open_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        cp_reg    <= cp_next;
        start_reg <= start_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_cp    = cp_reg;
    assign out_start = start_reg;
    assign out_last  = last_reg;

`ifndef ASSERT_OFF
    a_end_closes_word: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.op == KIND_END) |=> !word_open_reg)
        else $error("word still open after end of text");
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_END) |-> (!start_reg && last_reg && cp_reg == '0))
        else $error("end of text result with bad fields");
    a_stand_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_STAND) |-> start_reg)
        else $error("standalone character not marked as token start");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/upt_token_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upt_token_checker: result predictor and scoreboard for utf8_pretokenizer
// Watches both stream channels of the pre-tokenizer and keeps its own copy
// of the UTF-8 decode state. Each accepted text byte is turned into the
// token characters it should cause. Those are compared field by field with
// the results that leave the block, oldest first.
// ----------------------------------------------------------------------------
module upt_token_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_final,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [23:0] out_data,   // [20:0] code_point, [21] starts_token
    input  wire logic [1:0]  out_kind,   // [1:0] kind
    input  wire logic        out_last,   // run_end
    output int               fail_count,
    output int               left_count
);
    import upt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] cp;
        logic        starts;
        logic        run_end;
    } token_t;

    // decode state: held bytes, byte 0 in the lowest bits
    logic [31:0] held_v;
    logic [2:0]  held_cnt;
    logic [2:0]  want_len;
    logic        in_word;

    token_t due_tokens[$];
    token_t step_tokens[$];

    function automatic logic in_span(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic logic is_blank(logic [20:0] c);
        return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D ||
               c == 21'hA0 || c == 21'h1680 || in_span(c, 21'h2000, 21'h200A) ||
               c == 21'h2028 || c == 21'h2029 || c == 21'h202F ||
               c == 21'h205F || c == 21'h3000;
    endfunction

    // tab, newline and carriage return count as whitespace, not control
    function automatic logic is_control(logic [20:0] c);
        if (c == 21'h09 || c == 21'h0A || c == 21'h0D)
            return 1'b0;
        return c < 21'h20 || in_span(c, 21'h7F, 21'h9F) || c == REPLACEMENT_CP;
    endfunction

    function automatic logic is_han(logic [20:0] c);
        return in_span(c, 21'h3400, 21'h4DBF) || in_span(c, 21'h4E00, 21'h9FFF) ||
               in_span(c, 21'hF900, 21'hFAFF) || in_span(c, 21'h20000, 21'h2A6DF) ||
               in_span(c, 21'h2A700, 21'h2CEAF) || in_span(c, 21'h2F800, 21'h2FA1F);
    endfunction

    function automatic logic is_mark(logic [20:0] c);
        return in_span(c, 21'h21, 21'h2F) || in_span(c, 21'h3A, 21'h40) ||
               in_span(c, 21'h5B, 21'h60) || in_span(c, 21'h7B, 21'h7E) ||
               in_span(c, 21'h2000, 21'h206F) || in_span(c, 21'h2E00, 21'h2E7F) ||
               in_span(c, 21'h3001, 21'h303F) || in_span(c, 21'hFE10, 21'hFE1F) ||
               in_span(c, 21'hFE30, 21'hFE4F) || in_span(c, 21'hFF01, 21'hFF65);
    endfunction

    // length announced by a lead byte, zero when it cannot lead
    function automatic logic [2:0] seq_len(logic [7:0] b);
        if (!b[7])
            return 3'd1;
        if (b[7:5] == 3'b110)
            return 3'd2;
        if (b[7:4] == 4'b1110)
            return 3'd3;
        if (b[7:3] == 5'b11110)
            return 3'd4;
        return 3'd0;
    endfunction

    // lead payload, then six low bits of each following byte
    function automatic logic [20:0] assemble_cp(logic [31:0] s, logic [2:0] len);
        logic [20:0] cp;
        int k;
        case (len)
            3'd2:    cp = {16'd0, s[4:0]};
            3'd3:    cp = {17'd0, s[3:0]};
            3'd4:    cp = {18'd0, s[2:0]};
            default: cp = {13'd0, s[7:0]};
        endcase
        for (k = 1; k < len; k++)
            cp = {cp[14:0], s[8*k +: 6]};
        return cp;
    endfunction

    // classify one character and queue the token it makes, if any
    task automatic take_char(input logic [20:0] c);
        token_t t;
        if (!is_control(c))
        begin
            if (is_blank(c))
                in_word = 1'b0;
            else
            begin
                if (in_span(c, 21'h41, 21'h5A))
                    c = c + 21'h20;
                if (is_han(c) || is_mark(c))
                begin
                    t = {KIND_STAND, c, 1'b1, 1'b0};
                    in_word = 1'b0;
                end
                else
                begin
                    t = {KIND_WORD, c, !in_word, 1'b0};
                    in_word = 1'b1;
                end
                step_tokens = {step_tokens, t};
            end
        end
    endtask

    // tokens caused by one accepted text byte
    task automatic predict_byte(input logic [7:0] b, input logic last_b);
        logic [31:0] work_v;
        logic [2:0]  len;
        token_t      t;
        int          cnt;
        int          i;
        int          k;
        step_tokens.delete();
        if (!last_b)
        begin
            if (held_cnt == 3'd0)
            begin
                len = seq_len(b);
                if (len == 3'd1)
                    take_char({13'd0, b});
                else if (len == 3'd0)
                    take_char(REPLACEMENT_CP);
                else
                begin
                    held_v   = {24'd0, b};
                    held_cnt = 3'd1;
                    want_len = len;
                end
            end
            else
            begin
                held_v[8*held_cnt[1:0] +: 8] = b;
                held_cnt = held_cnt + 3'd1;
                if (held_cnt >= want_len || held_cnt >= 3'd4)
                begin
                    take_char(assemble_cp(held_v, want_len));
                    held_v   = '0;
                    held_cnt = 3'd0;
                    want_len = 3'd0;
                end
            end
        end
        else
        begin
            // end of text: held bytes plus this one are parsed again
            work_v = held_v;
            cnt = int'(held_cnt[1:0]);
            work_v[8*cnt +: 8] = b;
            cnt = cnt + 1;
            i = 0;
            while (i < cnt)
            begin
                len = seq_len(work_v[8*i +: 8]);
                if (len == 3'd1)
                begin
                    take_char({13'd0, work_v[8*i +: 8]});
                    i = i + 1;
                end
                else if (len != 3'd0 && i + len <= cnt)
                begin
                    take_char(assemble_cp(work_v >> (8*i), len));
                    i = i + len;
                end
                else
                begin
                    // truncated or invalid lead is dropped, the rest re-parsed
                    take_char(REPLACEMENT_CP);
                    i = i + 1;
                end
            end
            t = {KIND_END, 21'd0, 1'b0, 1'b0};
            step_tokens = {step_tokens, t};
            held_v   = '0;
            held_cnt = 3'd0;
            want_len = 3'd0;
            in_word  = 1'b0;
        end
        // the last token of this request carries run_end
        for (k = 0; k < step_tokens.size(); k++)
        begin
            t = step_tokens[k];
            t.run_end = (k == step_tokens.size() - 1);
            due_tokens = {due_tokens, t};
        end
    endtask

    task automatic log_mismatch(input string what, input logic [23:0] got,
                                input logic [23:0] want);
        $display("[%0t] %s mismatch: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // compare one result with the oldest expected token
    task automatic check_token();
        token_t t;
        if (due_tokens.size() == 0)
            log_mismatch("unexpected result", out_data, 24'd0);
        else
        begin
            t = due_tokens.pop_front();
            if (out_kind != t.kind)
                log_mismatch("kind", 24'(out_kind), 24'(t.kind));
            if (out_data[20:0] != t.cp)
                log_mismatch("code_point", 24'(out_data[20:0]), 24'(t.cp));
            if (out_data[21] != t.starts)
                log_mismatch("starts_token", 24'(out_data[21]), 24'(t.starts));
            if (out_last != t.run_end)
                log_mismatch("run_end", 24'(out_last), 24'(t.run_end));
            if (out_data[23:22] != 2'b00)
                log_mismatch("tdata padding", 24'(out_data[23:22]), 24'd0);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v   = '0;
            held_cnt = 3'd0;
            want_len = 3'd0;
            in_word  = 1'b0;
            due_tokens.delete();
            left_count = 0;
            fail_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_byte(in_byte, in_final);
            if (out_valid && out_ready)
                check_token();
            left_count = due_tokens.size();
        end
    end

endmodule

// ===== tb/sv/utf8_pretokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_pretokenizer_tb: stream testbench for the UTF-8 pre-tokenizer
// Sends a directed set of bytes covering each character class, invalid
// leads and truncated sequences at end of text, then random UTF-8 texts
// with noise, broken continuations and cut-off endings. Both sides stall
// in random bursts; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module utf8_pretokenizer_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 250;
    localparam int CALM_FROM = 195;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int left_count;
    int cycle_count = 0;
    int rand_sent;

    logic idle_on;
    logic stall_on;
    logic [7:0] text_bytes[$];

    utf8_pretokenizer DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    upt_token_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_final   (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_kind   (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .fail_count (fail_count),
        .left_count (left_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[utf8_pretokenizer] ERROR");
            $finish;
        end
    end

    // result side: random stall bursts while stall_on is set
    initial
    begin
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (stall_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge clk);
        end
    end

    // one byte request, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last_b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last_b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // append one byte to the text being built
    task automatic add_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endtask

    // utf-8 bytes of cp in len bytes; continuations sometimes get bad top bits
    task automatic put_utf8(input logic [20:0] cp, input int len);
        logic [7:0] b;
        int k;
        case (len)
            1:       add_byte(cp[7:0]);
            2:       add_byte({3'b110, cp[10:6]});
            3:       add_byte({4'b1110, cp[15:12]});
            default: add_byte({5'b11110, cp[20:18]});
        endcase
        for (k = len - 2; k >= 0; k--)
        begin
            b = {2'b10, cp[6*k +: 6]};
            if ($urandom_range(0, 24) == 0)
                b[7:6] = 2'($urandom_range(0, 3));
            add_byte(b);
        end
    endtask

    // one random character, mostly well formed
    task automatic add_char();
        logic [20:0] cp;
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        cp = 21'h61;
        if (pick < 25)
            cp = $urandom_range(0, 1) ? 21'($urandom_range('h41, 'h5A)) :
                                        21'($urandom_range('h61, 'h7A));
        else if (pick < 35)
            cp = 21'($urandom_range(0, 'h7F));
        else if (pick < 45)
        begin
            case ($urandom_range(0, 3))
                0:       cp = 21'h20;
                1:       cp = 21'h09;
                2:       cp = 21'h0A;
                default: cp = 21'h0D;
            endcase
        end
        else if (pick < 60)
        begin
            // edges of the character classes
            case ($urandom_range(0, 35))
                0:  cp = 21'h00A0;   1:  cp = 21'h1680;   2:  cp = 21'h2000;
                3:  cp = 21'h200A;   4:  cp = 21'h200B;   5:  cp = 21'h2028;
                6:  cp = 21'h2029;   7:  cp = 21'h202F;   8:  cp = 21'h205F;
                9:  cp = 21'h206F;   10: cp = 21'h3000;   11: cp = 21'h3001;
                12: cp = 21'h303F;   13: cp = 21'h3040;   14: cp = 21'h3400;
                15: cp = 21'h4DBF;   16: cp = 21'h4E00;   17: cp = 21'h9FFF;
                18: cp = 21'hF900;   19: cp = 21'hFAFF;   20: cp = 21'hFE10;
                21: cp = 21'hFE1F;   22: cp = 21'hFE30;   23: cp = 21'hFE4F;
                24: cp = 21'hFF01;   25: cp = 21'hFF65;   26: cp = 21'hFF66;
                27: cp = 21'hFFFD;   28: cp = 21'h2E00;   29: cp = 21'h2E7F;
                30: cp = 21'h20000;  31: cp = 21'h2A6DF;  32: cp = 21'h2A700;
                33: cp = 21'h2CEAF;  34: cp = 21'h2FA1F;  default: cp = 21'h9F;
            endcase
        end
        else if (pick < 70)
            cp = 21'($urandom_range('h80, 'h7FF));
        else if (pick < 80)
            cp = 21'($urandom_range('h800, 'hFFFF));
        else if (pick < 86)
            cp = 21'($urandom_range('h4E00, 'h9FFF));
        else if (pick < 92)
            cp = 21'($urandom_range('h10000, 'h1FFFFF));

        if (pick >= 92)
            add_byte(8'($urandom_range(0, 255)));
        else
        begin
            len = cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
            // overlong form now and then
            if (len < 4 && $urandom_range(0, 15) == 0)
                len = len + 1;
            put_utf8(cp, len);
        end
    endtask

    // stimulus
    initial
    begin
        int k;
        int cut;
        logic [20:0] tail_cp;
        int tail_len;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        idle_on       = 1'b1;
        stall_on      = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // capitals, whitespace, punctuation
        send_byte(8'h48, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h61, 1'b0);
        // dropped: control, delete, invalid leads
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // two-byte letter keeps the word open
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        // three-byte cjk
        send_byte(8'hE4, 1'b0);
        send_byte(8'hB8, 1'b0);
        send_byte(8'hAD, 1'b0);
        // largest code point a four-byte lead can carry
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // four-byte cjk extension, then a tab
        send_byte(8'hF0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h09, 1'b0);
        // truncated leads at end of text are re-parsed
        send_byte(8'hF0, 1'b0);
        send_byte(8'hE4, 1'b0);
        send_byte(8'h78, 1'b1);
        // open word closed by end of text, then a lone lead as final byte
        send_byte(8'h61, 1'b0);
        send_byte(8'hC3, 1'b1);

        // random texts
        rand_sent = 0;
        while (rand_sent < RANDOM_BYTES)
        begin
            text_bytes.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 14))
                    add_char();
            end
            // cut-off sequence at the end of the text
            if ($urandom_range(0, 4) == 0)
            begin
                tail_len = $urandom_range(2, 4);
                tail_cp  = tail_len == 2 ? 21'($urandom_range('h80, 'h7FF)) :
                           tail_len == 3 ? 21'($urandom_range('h800, 'hFFFF)) :
                                           21'($urandom_range('h10000, 'h1FFFFF));
                put_utf8(tail_cp, tail_len);
                cut = $urandom_range(1, tail_len - 1);
                repeat (cut)
                    text_bytes = text_bytes[0:$-1];
            end
            idle_on  = (rand_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            stall_on = (rand_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            for (k = 0; k < text_bytes.size(); k++)
                send_byte(text_bytes[k], k == text_bytes.size() - 1);
            rand_sent = rand_sent + text_bytes.size();
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for the output pipeline
        while (left_count != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (fail_count == 0)
            $display("[utf8_pretokenizer] OK");
        else
            $display("[utf8_pretokenizer] ERROR");
        $finish;
    end

endmodule
